// ===== sv/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the sphere pair collision core.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    typedef struct packed {
        logic both_finite;
        logic second_movable;
    } t_flags;

    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

// ===== sv/scc_front.sv =====
// ----------------------------------------------------------------------------
// scc_front
// Request intake: centre differences, squares and squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_front #(
    parameter int CW = 32,
    parameter int JW = 10 * CW + 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic signed [CW-1:0]  i_first_x,
    input  logic signed [CW-1:0]  i_first_y,
    input  logic signed [CW-1:0]  i_first_z,
    input  logic signed [CW-1:0]  i_second_x,
    input  logic signed [CW-1:0]  i_second_y,
    input  logic signed [CW-1:0]  i_second_z,
    input  logic [CW-2:0]         i_first_radius,
    input  logic [CW-2:0]         i_second_radius,
    input  scc_pkg::t_flags       i_flags,
    output logic                  o_wr,
    output logic [JW-1:0]         o_job,
    output logic [1:0]            o_inflight
);
    import scc_pkg::*;

    localparam int SW = 2 * CW + 2;

    typedef struct packed {
        logic [SW-1:0]        sum;
        logic [2:0][CW-1:0]   mag;
        logic [2:0]           sgn;
        logic [2:0][CW-1:0]   p1;
        logic [CW-2:0]        r1;
        logic [CW-1:0]        rsum;
        t_flags               fl;
    } t_job;

    logic signed [CW-1:0] fa [3];
    logic signed [CW-1:0] sa [3];

    logic                 r_f0_v;
    logic signed [CW:0]   r_f0_d [3];
    logic [2:0][CW-1:0]   r_f0_p1;
    logic [CW-2:0]        r_f0_r1;
    logic [CW-1:0]        r_f0_rsum;
    t_flags               r_f0_fl;

    logic [CW-1:0]        n_mag [3];
    logic                 r_f1_v;
    logic [2:0][CW-1:0]   r_f1_mag;
    logic [2:0]           r_f1_sgn;
    logic [2*CW-1:0]      r_f1_sq [3];
    logic [2:0][CW-1:0]   r_f1_p1;
    logic [CW-2:0]        r_f1_r1;
    logic [CW-1:0]        r_f1_rsum;
    t_flags               r_f1_fl;

    logic                 r_f2_v;
    t_job                 r_f2_job;

    always_comb begin
        fa[0] = i_first_x;
        fa[1] = i_first_y;
        fa[2] = i_first_z;
        sa[0] = i_second_x;
        sa[1] = i_second_y;
        sa[2] = i_second_z;
        for (int l = 0; l < 3; l++) begin
            n_mag[l] = r_f0_d[l][CW] ? CW'(-r_f0_d[l]) : CW'(r_f0_d[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f0_v <= i_acc;
            r_f1_v <= r_f0_v;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_f0_d[l]  <= {fa[l][CW-1], fa[l]} - {sa[l][CW-1], sa[l]};
            r_f0_p1[l] <= sa[l];
            r_f1_mag[l] <= n_mag[l];
            r_f1_sgn[l] <= r_f0_d[l][CW];
            r_f1_sq[l]  <= (2*CW)'(n_mag[l]) * (2*CW)'(n_mag[l]);
        end
        r_f0_r1   <= i_second_radius;
        r_f0_rsum <= {1'b0, i_first_radius} + {1'b0, i_second_radius};
        r_f0_fl   <= i_flags;
        r_f1_p1   <= r_f0_p1;
        r_f1_r1   <= r_f0_r1;
        r_f1_rsum <= r_f0_rsum;
        r_f1_fl   <= r_f0_fl;
        r_f2_job.sum  <= SW'(r_f1_sq[0]) + SW'(r_f1_sq[1]) + SW'(r_f1_sq[2]);
        r_f2_job.mag  <= r_f1_mag;
        r_f2_job.sgn  <= r_f1_sgn;
        r_f2_job.p1   <= r_f1_p1;
        r_f2_job.r1   <= r_f1_r1;
        r_f2_job.rsum <= r_f1_rsum;
        r_f2_job.fl   <= r_f1_fl;
    end

    assign o_wr       = r_f2_v;
    assign o_job      = r_f2_job;
    assign o_inflight = 2'(r_f0_v) + 2'(r_f1_v) + 2'(r_f2_v);

endmodule

`default_nettype wire

// ===== sv/scc_queue.sv =====
// ----------------------------------------------------------------------------
// scc_queue
// Short request queue between intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_queue #(
    parameter int W = 326
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [W-1:0]              i_data,
    input  logic                      i_rd,
    output logic                      o_valid,
    output logic [W-1:0]              o_data,
    output logic [scc_pkg::QCNTW-1:0] o_count
);
    import scc_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    logic [W-1:0]     r_mem [QDEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [QCNTW-1:0] r_count;
    logic [QCNTW-1:0] n_count;
    logic             rd_ok;

    assign rd_ok = i_rd && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_wr && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && rd_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== sv/scc_back.sv =====
// ----------------------------------------------------------------------------
// scc_back
// Arithmetic pipeline: square root, normal division, push and contact.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_back #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int JW = 10 * CW + 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  logic [JW-1:0]        i_job,
    output logic                 o_job_take,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_hit,
    output logic signed [FB+1:0] o_normal_x,
    output logic signed [FB+1:0] o_normal_y,
    output logic signed [FB+1:0] o_normal_z,
    output logic signed [CW-1:0] o_push_x,
    output logic signed [CW-1:0] o_push_y,
    output logic signed [CW-1:0] o_push_z,
    output logic signed [CW-1:0] o_contact_x,
    output logic signed [CW-1:0] o_contact_y,
    output logic signed [CW-1:0] o_contact_z
);
    import scc_pkg::*;

    localparam int SW  = 2 * CW + 2;
    localparam int RW  = CW + 1;
    localparam int RMW = RW + 2;
    localparam int DW  = RW + 1;
    localparam int MW  = FB + 1;
    localparam int NW  = FB + 2;
    localparam int PW  = MW + CW;
    localparam int AW  = CW + 2;
    localparam int NDS = FB + 1;
    localparam logic [MW-1:0]        UNIT = {1'b1, {FB{1'b0}}};
    localparam logic signed [AW-1:0] SMAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {3'b111, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [SW-1:0]        sum;
        logic [2:0][CW-1:0]   mag;
        logic [2:0]           sgn;
        logic [2:0][CW-1:0]   p1;
        logic [CW-2:0]        r1;
        logic [CW-1:0]        rsum;
        t_flags               fl;
    } t_job;

    typedef struct packed {
        t_job           job;
        logic           hit;
        logic           coin;
        logic [CW-1:0]  ovl;
        logic [RW-1:0]  den;
    } t_mid;

    function automatic logic signed [CW-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SMAX) begin
            r = SMAX[CW-1:0];
        end else if (v < SMIN) begin
            r = SMIN[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] f_sx(input logic signed [CW-1:0] v);
        return {{2{v[CW-1]}}, v};
    endfunction

    logic adv;
    logic r_out_v;

    assign adv        = !r_out_v || i_pop;
    assign o_job_take = adv && i_job_valid;

    // square root, one result bit per stage
    logic            r_sq_v    [RW];
    t_job            r_sq_job  [RW];
    logic [RMW-1:0]  r_sq_rem  [RW];
    logic [RW-1:0]   r_sq_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_sq
        logic           pv;
        t_job           pj;
        logic [RMW-1:0] prem;
        logic [RW-1:0]  proot;
        logic [RMW-1:0] rsh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_src0
            always_comb begin
                pv    = i_job_valid;
                pj    = t_job'(i_job);
                prem  = '0;
                proot = '0;
            end
        end else begin : g_srcn
            always_comb begin
                pv    = r_sq_v[k-1];
                pj    = r_sq_job[k-1];
                prem  = r_sq_rem[k-1];
                proot = r_sq_root[k-1];
            end
        end

        always_comb begin
            rsh   = {prem[RMW-3:0], pj.sum[SW-1-2*k -: 2]};
            trial = {proot, 2'b01};
            ge    = (rsh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_job[k]  <= pj;
                r_sq_rem[k]  <= ge ? rsh - trial : rsh;
                r_sq_root[k] <= {proot[RW-2:0], ge};
            end
        end
    end

    // hit test and overlap
    logic          r_md_v;
    t_mid          r_md;
    logic [RW-1:0] sq_dist;
    t_job          sq_job;

    assign sq_dist = r_sq_root[RW-1];
    assign sq_job  = r_sq_job[RW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md_v <= 1'b0;
        end else if (adv) begin
            r_md_v <= r_sq_v[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_md.job  <= sq_job;
            r_md.hit  <= (sq_dist <= {1'b0, sq_job.rsum});
            r_md.coin <= (sq_dist == '0);
            r_md.ovl  <= sq_job.rsum - sq_dist[CW-1:0];
            r_md.den  <= (sq_dist == '0) ? RW'(1) : sq_dist;
        end
    end

    // normal division, three lanes, one quotient bit per stage
    logic           r_dv_v   [NDS];
    t_mid           r_dv_m   [NDS];
    logic [RW-1:0]  r_dv_rem [NDS][3];
    logic [MW-1:0]  r_dv_q   [NDS][3];

    for (genvar j = 0; j < NDS; j++) begin : g_dv
        logic          pv;
        t_mid          pm;
        logic [DW-1:0] t   [3];
        logic [MW-1:0] pq  [3];
        logic          ge  [3];

        if (j == 0) begin : g_src0
            always_comb begin
                pv = r_md_v;
                pm = r_md;
                for (int l = 0; l < 3; l++) begin
                    t[l]  = DW'(r_md.job.mag[l]);
                    pq[l] = '0;
                end
            end
        end else begin : g_srcn
            always_comb begin
                pv = r_dv_v[j-1];
                pm = r_dv_m[j-1];
                for (int l = 0; l < 3; l++) begin
                    t[l]  = {r_dv_rem[j-1][l], 1'b0};
                    pq[l] = r_dv_q[j-1][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                ge[l] = (t[l] >= DW'(pm.den));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (adv) begin
                r_dv_v[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_m[j] <= pm;
                for (int l = 0; l < 3; l++) begin
                    r_dv_rem[j][l] <= ge[l] ? RW'(t[l] - DW'(pm.den)) : RW'(t[l]);
                    r_dv_q[j][l]   <= {pq[l][MW-2:0], ge[l]};
                end
            end
        end
    end

    // normal magnitude and products
    logic          r_x_v;
    t_mid          r_x_m;
    logic [MW-1:0] r_x_nmag [3];
    logic [PW-1:0] r_x_pm   [3];
    logic [PW-1:0] r_x_cm   [3];
    logic [MW-1:0] n_nmag   [3];
    t_mid          dv_m;

    assign dv_m = r_dv_m[NDS-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (dv_m.coin) begin
                n_nmag[l] = (l == 1) ? UNIT : '0;
            end else if (r_dv_q[NDS-1][l] > UNIT) begin
                n_nmag[l] = UNIT;
            end else begin
                n_nmag[l] = r_dv_q[NDS-1][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (adv) begin
            r_x_v <= r_dv_v[NDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_m <= dv_m;
            for (int l = 0; l < 3; l++) begin
                r_x_nmag[l] <= n_nmag[l];
                r_x_pm[l]   <= PW'(n_nmag[l]) * PW'(dv_m.ovl);
                r_x_cm[l]   <= PW'(n_nmag[l]) * PW'(dv_m.job.r1);
            end
        end
    end

    // push and moved second centre
    logic                  r_p_v;
    logic                  r_p_hit;
    logic [2:0]            r_p_sgn;
    logic signed [NW-1:0]  r_p_nrm  [3];
    logic signed [CW-1:0]  r_p_push [3];
    logic signed [CW-1:0]  r_p_c1   [3];
    logic [CW-1:0]         r_p_cm   [3];
    logic [PW-1:0]         pmag     [3];
    logic signed [AW-1:0]  pval     [3];
    logic signed [CW-1:0]  n_push   [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            pmag[l]   = r_x_m.job.fl.both_finite ? (r_x_pm[l] >> (FB + 1))
                                                 : (r_x_pm[l] >> FB);
            pval[l]   = r_x_m.job.sgn[l] ? -AW'(pmag[l][CW-1:0]) : AW'(pmag[l][CW-1:0]);
            n_push[l] = f_sat(pval[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (adv) begin
            r_p_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_hit <= r_x_m.hit;
            r_p_sgn <= r_x_m.job.sgn;
            for (int l = 0; l < 3; l++) begin
                r_p_nrm[l]  <= r_x_m.job.sgn[l] ? -NW'(r_x_nmag[l]) : NW'(r_x_nmag[l]);
                r_p_push[l] <= n_push[l];
                r_p_c1[l]   <= r_x_m.job.fl.second_movable
                             ? f_sat(f_sx(r_x_m.job.p1[l]) - f_sx(n_push[l]))
                             : r_x_m.job.p1[l];
                r_p_cm[l]   <= CW'(r_x_cm[l] >> FB);
            end
        end
    end

    // contact point and result register
    logic                  r_out_hit;
    logic signed [NW-1:0]  r_out_nrm  [3];
    logic signed [CW-1:0]  r_out_push [3];
    logic signed [CW-1:0]  r_out_con  [3];
    logic signed [AW-1:0]  cval       [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            cval[l] = r_p_sgn[l] ? -AW'(r_p_cm[l]) : AW'(r_p_cm[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_hit <= r_p_hit;
            for (int l = 0; l < 3; l++) begin
                r_out_nrm[l]  <= r_p_hit ? r_p_nrm[l] : '0;
                r_out_push[l] <= r_p_hit ? r_p_push[l] : '0;
                r_out_con[l]  <= r_p_hit ? f_sat(f_sx(r_p_c1[l]) + cval[l]) : '0;
            end
        end
    end

    assign o_empty     = !r_out_v;
    assign o_hit       = r_out_hit;
    assign o_normal_x  = r_out_nrm[0];
    assign o_normal_y  = r_out_nrm[1];
    assign o_normal_z  = r_out_nrm[2];
    assign o_push_x    = r_out_push[0];
    assign o_push_y    = r_out_push[1];
    assign o_push_z    = r_out_push[2];
    assign o_contact_x = r_out_con[0];
    assign o_contact_y = r_out_con[1];
    assign o_contact_z = r_out_con[2];

endmodule

`default_nettype wire

// ===== sv/sphere_pair_collision_core.sv =====
// ----------------------------------------------------------------------------
// sphere_pair_collision_core
// Sphere against sphere narrow-phase test with normal, push and contact.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: an item is taken on a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on the o_ ports while empty is low and is removed by pop.
// One request per cycle is sustained while results are popped as they come.
// A request passes through three intake stages, one queue slot, one
// square root stage per result bit (CW + 1), a hit and overlap stage, one
// division stage per normal bit (FB + 1), then product, push and contact
// stages.
// The intake never stalls; full rises once the queue plus the intake stages
// hold QDEPTH requests. While a result waits and pop stays low the arithmetic
// pipeline holds as a whole while the queue keeps filling.
// Synchronous reset empties queue and pipeline; no results are pending after.
// first_movable has no effect on any result.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_pair_collision_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [COORD_WIDTH-1:0]  i_first_x,
    input  logic signed [COORD_WIDTH-1:0]  i_first_y,
    input  logic signed [COORD_WIDTH-1:0]  i_first_z,
    input  logic signed [COORD_WIDTH-1:0]  i_second_x,
    input  logic signed [COORD_WIDTH-1:0]  i_second_y,
    input  logic signed [COORD_WIDTH-1:0]  i_second_z,
    input  logic [COORD_WIDTH-2:0]         i_first_radius,
    input  logic [COORD_WIDTH-2:0]         i_second_radius,
    input  logic                           i_first_mass_finite,
    input  logic                           i_second_mass_finite,
    input  logic                           i_first_movable,
    input  logic                           i_second_movable,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_hit,
    output logic signed [FRAC_BITS+1:0]    o_normal_x,
    output logic signed [FRAC_BITS+1:0]    o_normal_y,
    output logic signed [FRAC_BITS+1:0]    o_normal_z,
    output logic signed [COORD_WIDTH-1:0]  o_push_x,
    output logic signed [COORD_WIDTH-1:0]  o_push_y,
    output logic signed [COORD_WIDTH-1:0]  o_push_z,
    output logic signed [COORD_WIDTH-1:0]  o_contact_x,
    output logic signed [COORD_WIDTH-1:0]  o_contact_y,
    output logic signed [COORD_WIDTH-1:0]  o_contact_z
);
    import scc_pkg::*;

    localparam int JW = 10 * COORD_WIDTH + 6;
    localparam logic signed [FRAC_BITS+1:0] NUNIT = {2'b01, {FRAC_BITS{1'b0}}};

    logic            acc;
    t_flags          flags;
    logic            f_wr;
    logic [JW-1:0]   f_job;
    logic [1:0]      f_inflight;
    logic            q_valid;
    logic [JW-1:0]   q_data;
    logic [QCNTW-1:0] q_count;
    logic            b_take;
    logic [QCNTW:0]  occ;

    assign acc   = push && !full;
    assign occ   = (QCNTW+1)'(q_count) + (QCNTW+1)'(f_inflight);
    assign full  = (occ >= (QCNTW+1)'(QDEPTH));

    always_comb begin
        flags.both_finite    = i_first_mass_finite & i_second_mass_finite;
        flags.second_movable = i_second_movable;
    end

    scc_front #(
        .CW (COORD_WIDTH),
        .JW (JW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc           (acc),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_z       (i_first_z),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_z      (i_second_z),
        .i_first_radius  (i_first_radius),
        .i_second_radius (i_second_radius),
        .i_flags         (flags),
        .o_wr            (f_wr),
        .o_job           (f_job),
        .o_inflight      (f_inflight)
    );

    scc_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_data  (f_job),
        .i_rd    (b_take),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    scc_back #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS),
        .JW (JW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_data),
        .o_job_take  (b_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hit       (o_hit),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .o_push_x    (o_push_x),
        .o_push_y    (o_push_y),
        .o_push_z    (o_push_z),
        .o_contact_x (o_contact_x),
        .o_contact_y (o_contact_y),
        .o_contact_z (o_contact_z)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNTW'(QDEPTH))
        else $error("request queue over capacity");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_wr |-> (q_count < QCNTW'(QDEPTH)) || b_take)
        else $error("request queue written while full");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> (o_normal_y == '0 && o_push_x == '0 && o_contact_x == '0))
        else $error("miss result not cleared");

    a_normal_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit) |-> (o_normal_y <= NUNIT && o_normal_y >= -NUNIT))
        else $error("normal component beyond unit");
`endif

endmodule

`default_nettype wire
